### rtl/lsme_pkg.sv
// Shared types, codes and plan builders for the lane sign mode/event sequencer.
// No dependencies; imported by every module of the block.
package lsme_pkg;

	// Event codes
	localparam logic [4:0] EV_REMOTE       = 5'd0;
	localparam logic [4:0] EV_REMOTE_NORM  = 5'd1;
	localparam logic [4:0] EV_REMOTE_SHIFT = 5'd2;
	localparam logic [4:0] EV_SCHED_N2S    = 5'd3;
	localparam logic [4:0] EV_SCHED_S2N    = 5'd4;
	localparam logic [4:0] EV_MAN_NORM     = 5'd5;
	localparam logic [4:0] EV_MAN_CLR      = 5'd6;
	localparam logic [4:0] EV_MAN_SHIFT    = 5'd7;
	localparam logic [4:0] EV_SW_NORM      = 5'd8;
	localparam logic [4:0] EV_SW_CLR       = 5'd9;
	localparam logic [4:0] EV_SW_SHIFT     = 5'd10;
	localparam logic [4:0] EV_MAN_FAIL     = 5'd11;
	localparam logic [4:0] EV_MONITOR      = 5'd12;
	localparam logic [4:0] EV_MON_RELEASE  = 5'd13;
	localparam logic [4:0] EV_FAIL         = 5'd14;
	localparam logic [4:0] EV_POWER_OFF    = 5'd15;
	localparam logic [4:0] EV_POWER_ON     = 5'd16;
	localparam logic [4:0] EV_FAULT_CLR    = 5'd17;
	localparam logic [4:0] EV_FAIL_BACK    = 5'd18;
	localparam logic [4:0] EV_UB_NORM      = 5'd19;
	localparam logic [4:0] EV_UB_CLR       = 5'd20;
	localparam logic [4:0] EV_UB_SHIFT     = 5'd21;
	localparam logic [4:0] EV_UB_FAIL      = 5'd22;

	// Display status codes
	localparam logic [2:0] ST_NORM  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_FAIL  = 3'd3;
	localparam logic [2:0] ST_CLR_N = 3'd4;
	localparam logic [2:0] ST_CLR_S = 3'd5;

	// Display change commands
	localparam logic [2:0] CMD_NORM  = 3'd0;
	localparam logic [2:0] CMD_CLR   = 3'd1;
	localparam logic [2:0] CMD_SHIFT = 3'd2;
	localparam logic [2:0] CMD_FAIL  = 3'd3;
	localparam logic [2:0] CMD_WAIT  = 3'd4;
	localparam logic [2:0] CMD_POFF  = 3'd5;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OPM_REMOTE  = 2'd0,
		OPM_MANUAL  = 2'd1,
		OPM_MONITOR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OUT_HANDLED = 2'd0,
		OUT_BUSY    = 2'd1,
		OUT_REFUSED = 2'd2
	} outcome_t;

	// One classified event: up to three commands plus per-event flags
	typedef struct packed {
		logic [2:0] c0;
		logic [2:0] c1;
		logic [2:0] c2;
		logic [1:0] n_cmd;
		logic       flush;
		outcome_t   outcome;
	} plan_t;

	typedef struct packed {
		mode_t mode;
		logic  outage;
	} front_status_t;

	function automatic plan_t plan0();
		plan_t p;
		p = '{c0: CMD_NORM, c1: CMD_NORM, c2: CMD_NORM, n_cmd: 2'd0,
			flush: 1'b0, outcome: OUT_HANDLED};
		return p;
	endfunction

	function automatic plan_t plan1(input logic [2:0] a);
		plan_t p;
		p = plan0();
		p.c0 = a;
		p.n_cmd = 2'd1;
		return p;
	endfunction

	function automatic plan_t plan2(input logic [2:0] a, input logic [2:0] b);
		plan_t p;
		p = plan1(a);
		p.c1 = b;
		p.n_cmd = 2'd2;
		return p;
	endfunction

	function automatic plan_t plan3(input logic [2:0] a, input logic [2:0] b,
			input logic [2:0] c);
		plan_t p;
		p = plan2(a, b);
		p.c2 = c;
		p.n_cmd = 2'd3;
		return p;
	endfunction

	// Status used as a target: plain states map 1:1, both clear variants to clear
	function automatic plan_t status_plan(input logic [2:0] st);
		plan_t p;
		if (st <= ST_FAIL) begin
			p = plan1(st);
		end else if (st == ST_CLR_N || st == ST_CLR_S) begin
			p = plan1(CMD_CLR);
		end else begin
			p = plan0();
		end
		return p;
	endfunction

endpackage

### rtl/lsme_front.sv
// Front end: classifies each accepted event into a command plan and
// updates mode, outage flag and fault pattern. Depends on lsme_pkg.
module lsme_front import lsme_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [4:0]    event_code,
	input  logic [2:0]    current_status,
	input  logic [2:0]    schedule_status,
	input  logic [2:0]    status_before_fail,
	input  logic          queue_empty,
	input  logic          rotation_busy,
	input  logic          error_present,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_wr_data,
	output plan_t         plan,
	output front_status_t status
);

	mode_t      mode_q, mode_d;
	logic       outage_q, outage_d;
	logic [2:0] fault_pat_q;
	logic       busy;
	logic [4:0] ev;
	logic [2:0] st, sch;

	assign st  = current_status;
	assign sch = schedule_status;

	always_comb begin
		busy = event_code != EV_REMOTE && event_code != EV_FAIL
			&& (!queue_empty || rotation_busy);
		// plain remote request resolves by schedule
		if (event_code == EV_REMOTE) begin
			ev = (sch == ST_NORM || sch == ST_CLR_N || sch == ST_CLR_S)
				? EV_REMOTE_NORM : EV_REMOTE_SHIFT;
		end else begin
			ev = event_code;
		end
	end

	always_comb begin
		plan     = plan0();
		mode_d   = mode_q;
		outage_d = outage_q;
		if (busy) begin
			plan.outcome = OUT_BUSY;
		end else begin
			unique case (ev)
				EV_REMOTE_NORM: begin
					if (mode_q == OPM_MANUAL) begin
						if (st == ST_NORM) mode_d = OPM_REMOTE;
						else if (st == ST_CLR) begin
							mode_d = OPM_REMOTE;
							plan = plan2(CMD_WAIT, CMD_NORM);
						end else if (st == ST_SHIFT) begin
							mode_d = OPM_REMOTE;
							plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
						end else if (st == ST_FAIL) plan = plan1(CMD_NORM);
					end else if (mode_q == OPM_REMOTE && st == ST_FAIL) begin
						plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
					end
				end
				EV_REMOTE_SHIFT: begin
					if (mode_q == OPM_MANUAL) begin
						if (st == ST_NORM) begin
							mode_d = OPM_REMOTE;
							plan = plan3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						end else if (st == ST_CLR) begin
							mode_d = OPM_REMOTE;
							plan = plan2(CMD_WAIT, CMD_SHIFT);
						end else if (st == ST_SHIFT) mode_d = OPM_REMOTE;
					end else if (mode_q == OPM_REMOTE && st == ST_FAIL) begin
						plan = plan3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
					end
				end
				EV_SCHED_N2S: begin
					if (mode_q == OPM_REMOTE) begin
						if (error_present) plan = plan1(CMD_FAIL);
						else if (st == ST_NORM) plan = plan3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
					end
				end
				EV_SCHED_S2N: begin
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_SHIFT) plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
						else if (st == ST_FAIL) plan = plan1(CMD_NORM);
					end
				end
				EV_MAN_NORM: begin
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_NORM) mode_d = OPM_MANUAL;
						else if (st == ST_SHIFT) begin
							mode_d = OPM_MANUAL;
							plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
						end
					end else if (mode_q == OPM_MANUAL) begin
						if (st == ST_CLR || st == ST_FAIL) plan = plan1(CMD_NORM);
						else if (st == ST_SHIFT) plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
					end
				end
				EV_MAN_CLR: begin
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_NORM || st == ST_SHIFT) begin
							mode_d = OPM_MANUAL;
							plan = plan1(CMD_CLR);
						end
					end else if (mode_q == OPM_MANUAL) begin
						if (st == ST_NORM || st == ST_SHIFT || st == ST_FAIL)
							plan = plan1(CMD_CLR);
					end
				end
				EV_MAN_SHIFT: begin
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_NORM) begin
							mode_d = OPM_MANUAL;
							plan = plan3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						end else if (st == ST_SHIFT) mode_d = OPM_MANUAL;
					end else if (mode_q == OPM_MANUAL) begin
						if (st == ST_NORM) plan = plan3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						else if (st == ST_CLR || st == ST_FAIL) plan = plan1(CMD_SHIFT);
					end
				end
				EV_SW_NORM: begin
					plan.outcome = OUT_REFUSED;
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_NORM) begin
							mode_d = OPM_MANUAL;
							plan.outcome = OUT_HANDLED;
						end else if (st == ST_FAIL || st == ST_CLR) begin
							mode_d = OPM_MANUAL;
							plan = plan1(CMD_NORM);
						end
					end else if (mode_q == OPM_MANUAL) begin
						if (st == ST_NORM || st == ST_CLR || st == ST_FAIL)
							plan = plan1(CMD_NORM);
					end
				end
				EV_SW_CLR: begin
					plan.outcome = OUT_REFUSED;
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_NORM || st == ST_FAIL || st == ST_SHIFT) begin
							mode_d = OPM_MANUAL;
							plan = plan1(CMD_CLR);
						end
					end else if (mode_q == OPM_MANUAL) begin
						if (st <= ST_FAIL) plan = plan1(CMD_CLR);
					end
				end
				EV_SW_SHIFT: begin
					plan.outcome = OUT_REFUSED;
					if (mode_q == OPM_REMOTE) begin
						if (st == ST_CLR || st == ST_FAIL) begin
							mode_d = OPM_MANUAL;
							plan = plan1(CMD_SHIFT);
						end else if (st == ST_SHIFT) begin
							mode_d = OPM_MANUAL;
							plan.outcome = OUT_HANDLED;
						end
					end else if (mode_q == OPM_MANUAL) begin
						if (st == ST_CLR || st == ST_SHIFT || st == ST_FAIL)
							plan = plan1(CMD_SHIFT);
					end
				end
				EV_MAN_FAIL: begin
					if (st <= ST_SHIFT
						&& (mode_q == OPM_REMOTE || mode_q == OPM_MANUAL)) begin
						mode_d = OPM_MANUAL;
						plan = plan1(CMD_FAIL);
					end else begin
						plan.outcome = OUT_REFUSED;
					end
				end
				EV_MONITOR: begin
					if (mode_q == OPM_REMOTE || mode_q == OPM_MONITOR
						|| mode_q == OPM_MANUAL) begin
						if (st == ST_CLR || st == ST_FAIL) plan = plan1(CMD_NORM);
						else if (st == ST_SHIFT) plan = plan3(CMD_CLR, CMD_WAIT, CMD_NORM);
					end
					mode_d = OPM_MONITOR;
				end
				EV_MON_RELEASE: begin
					if (st == ST_NORM) plan = plan1(CMD_NORM);
					else if (st == ST_CLR || st == ST_FAIL) plan = plan1(CMD_WAIT);
					else if (st == ST_SHIFT) plan = plan2(CMD_CLR, CMD_WAIT);
					mode_d = OPM_REMOTE;
				end
				EV_FAIL: begin
					if (mode_q == OPM_REMOTE && (sch == ST_CLR_N || sch == ST_CLR
						|| sch == ST_SHIFT || sch == ST_CLR_S)) begin
						if (st != ST_FAIL) plan = plan1(CMD_FAIL);
					end else begin
						plan.outcome = OUT_REFUSED;
					end
				end
				EV_POWER_OFF: begin
					if ((mode_q == OPM_REMOTE || mode_q == OPM_MANUAL)
						&& st == ST_SHIFT) begin
						plan = plan1(CMD_POFF);
						plan.flush = 1'b1;
						outage_d = 1'b1;
					end else begin
						plan.outcome = OUT_REFUSED;
					end
				end
				EV_POWER_ON: begin
					// skip the restore when the fault pattern already shows the target
					if (sch == ST_NORM || sch == ST_CLR_S) begin
						if (fault_pat_q != ST_NORM) plan = plan1(CMD_NORM);
					end else if (sch == ST_CLR) begin
						if (fault_pat_q != ST_CLR) plan = plan1(CMD_CLR);
					end else if (sch == ST_SHIFT || sch == ST_CLR_N) begin
						if (fault_pat_q != ST_SHIFT) plan = plan2(CMD_WAIT, CMD_SHIFT);
					end
					outage_d = 1'b0;
				end
				EV_FAULT_CLR: begin
					if (st == ST_FAIL) begin
						if (mode_q == OPM_REMOTE) plan = status_plan(sch);
						else if (mode_q == OPM_MANUAL) plan = status_plan(status_before_fail);
						else if (mode_q == OPM_MONITOR) plan = plan1(CMD_NORM);
					end
				end
				EV_FAIL_BACK: begin
					mode_d = OPM_REMOTE;
					if (st == ST_FAIL) plan = plan1(CMD_NORM);
				end
				EV_UB_NORM, EV_UB_CLR, EV_UB_SHIFT, EV_UB_FAIL: begin
					if (mode_q == OPM_REMOTE) plan = plan1(3'(ev - EV_UB_NORM));
					else plan.outcome = OUT_REFUSED;
				end
				default: begin
					plan.outcome = OUT_REFUSED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= OPM_REMOTE;
			outage_q    <= 1'b0;
			fault_pat_q <= ST_NORM;
		end else begin
			if (accept) begin
				mode_q   <= mode_d;
				outage_q <= outage_d;
			end
			if (cfg_wr_en) fault_pat_q <= cfg_wr_data;
		end
	end

	assign status.mode   = mode_q;
	assign status.outage = outage_q;

endmodule

### rtl/lsme_queue.sv
// Small FIFO of classified event plans between front and back end.
// Depends on lsme_pkg for plan_t.
module lsme_queue import lsme_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output plan_t head_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	plan_t          entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

### rtl/lsme_back.sv
// Back end: walks the head plan into the output register one result per cycle
// while out_ready allows. Depends on lsme_pkg.
module lsme_back import lsme_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  plan_t      head_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] command,
	output logic       has_command,
	output logic       flush_queue,
	output logic [1:0] outcome,
	output logic       last
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       load, is_last;
	logic [2:0] cmd_sel;
	logic       out_valid_q;

	assign load     = head_valid && (!out_valid_q || out_ready);
	// a plan with no command still yields one result
	assign last_idx = (head_data.n_cmd == 2'd0) ? 2'd0 : head_data.n_cmd - 2'd1;
	assign is_last  = idx_q == last_idx;
	assign pop      = load && is_last;

	always_comb begin
		unique case (idx_q)
			2'd0:    cmd_sel = head_data.c0;
			2'd1:    cmd_sel = head_data.c1;
			default: cmd_sel = head_data.c2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			command     <= (head_data.n_cmd == 2'd0) ? CMD_NORM : cmd_sel;
			has_command <= head_data.n_cmd != 2'd0;
			flush_queue <= head_data.flush && idx_q == 2'd0;
			outcome     <= head_data.outcome;
			last        <= is_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/lane_sign_mode_event_sequencer.sv
// Top level of the lane sign mode/event sequencer: front classifier, plan
// queue and back-end result sequencer. Depends on lsme_pkg and the lsme_* modules.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_ready    | event_code, current_status, schedule_status,
//          |                        | status_before_fail, queue_empty,
//          |                        | rotation_busy, error_present
//  out     | out_valid / out_ready  | command, has_command, flush_queue,
//          |                        | outcome, last
//  cfg     | cfg_wr_en (no wait)    | cfg_wr_data = fault pattern
//
// An event is classified in the cycle it is accepted; mode and outage flag update
// at that edge, so the next event can be accepted in the very next cycle.
// Each event yields 1 to 3 result transactions, one per cycle from the back end
// while out_ready holds; the plan queue takes new events meanwhile.
// The first result of an event is registered in the plan queue and then in the
// output register before out_valid shows it.
// Input stalls only when the QUEUE_DEPTH-entry plan queue is full; output stalls
// hold the output register. Reset: remote mode, no outage, fault pattern normal.
module lane_sign_mode_event_sequencer import lsme_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] event_code,
	input  logic [2:0] current_status,
	input  logic [2:0] schedule_status,
	input  logic [2:0] status_before_fail,
	input  logic       queue_empty,
	input  logic       rotation_busy,
	input  logic       error_present,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] command,
	output logic       has_command,
	output logic       flush_queue,
	output logic [1:0] outcome,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data
);

	plan_t         front_plan, head_plan;
	front_status_t front_status;
	logic          accept, q_full, head_valid, pop;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	lsme_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.event_code         (event_code),
		.current_status     (current_status),
		.schedule_status    (schedule_status),
		.status_before_fail (status_before_fail),
		.queue_empty        (queue_empty),
		.rotation_busy      (rotation_busy),
		.error_present      (error_present),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data),
		.plan               (front_plan),
		.status             (front_status)
	);

	lsme_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (front_plan),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_plan)
	);

	lsme_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_plan),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.command     (command),
		.has_command (has_command),
		.flush_queue (flush_queue),
		.outcome     (outcome),
		.last        (last)
	);

	// A command-less result is always the single, final result of its event
	a_nocmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_command |-> command == CMD_NORM && last)
		else $error("command-less result not a lone last result");

	// Flush only rides on a handled power-off command
	a_flush_poff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flush_queue |-> has_command && command == CMD_POFF
			&& outcome == OUT_HANDLED)
		else $error("flush without handled power-off");

	// Outage flag is only raised by an accepted power-off event
	a_outage_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(front_status.outage) |-> $past(accept && event_code == EV_POWER_OFF))
		else $error("outage flag set without power-off transaction");

	// Plan queue never pops while empty
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("plan queue popped while empty");

endmodule

### tb/tb_lane_sign_mode_event_sequencer.sv
// Self-checking testbench for lane_sign_mode_event_sequencer: event transactions
// in, command transactions out, checked against an in-bench predictor.
// Depends on lsme_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_lane_sign_mode_event_sequencer;
	import lsme_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;   // a little past the block's latency

	// One request event as presented on the input channel
	typedef struct packed {
		logic [4:0] event_code;
		logic [2:0] current_status;
		logic [2:0] schedule_status;
		logic [2:0] status_before_fail;
		logic       queue_empty;
		logic       rotation_busy;
		logic       error_present;
	} event_item_t;

	// One command transaction as seen on the output channel
	typedef struct packed {
		logic [2:0] command;
		logic       has_command;
		logic       flush_queue;
		logic [1:0] outcome;
		logic       last;
	} cmd_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [4:0] event_code;
	logic [2:0] current_status;
	logic [2:0] schedule_status;
	logic [2:0] status_before_fail;
	logic       queue_empty;
	logic       rotation_busy;
	logic       error_present;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] command;
	logic       has_command;
	logic       flush_queue;
	logic [1:0] outcome;
	logic       last;
	logic       cfg_wr_en;
	logic [2:0] cfg_wr_data;

	// Predictor state: mirrors the block's mode, outage flag and fault pattern
	mode_t       op_mode;
	logic        outage_flag;
	logic [2:0]  fault_pat;

	// Commands of the event being predicted, and the flush marker for the first
	logic [2:0]  event_cmds[$];
	bit          flush_first;

	// Command transactions still owed by the block, oldest first
	cmd_result_t due_results[$];

	int  error_count;
	int  cycle_count;
	bit  no_gaps;        // set for stretches with back-to-back traffic on both sides

	lane_sign_mode_event_sequencer dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.event_code         (event_code),
		.current_status     (current_status),
		.schedule_status    (schedule_status),
		.status_before_fail (status_before_fail),
		.queue_empty        (queue_empty),
		.rotation_busy      (rotation_busy),
		.error_present      (error_present),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.command            (command),
		.has_command        (has_command),
		.flush_queue        (flush_queue),
		.outcome            (outcome),
		.last               (last),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// At most three commands per event, as a plan holds; extras are dropped
	function automatic void push_cmd(input logic [2:0] c);
		if (event_cmds.size() < 3) begin
			event_cmds.push_back(c);
		end
	endfunction

	// Standard clear / offset-wait / target rotation
	function automatic void push3(input logic [2:0] a, input logic [2:0] b,
			input logic [2:0] c);
		push_cmd(a);
		push_cmd(b);
		push_cmd(c);
	endfunction

	// Status as target: plain states map straight, clear variants to clear,
	// unused codes give nothing
	function automatic void push_status(input logic [2:0] st);
		if (st <= ST_FAIL) begin
			push_cmd(st);
		end else if (st == ST_CLR_N || st == ST_CLR_S) begin
			push_cmd(CMD_CLR);
		end
	endfunction

	// Works out the command transactions one accepted event causes, updates
	// the mirrored state and queues the transactions as expectations
	function automatic void predict_event_cmds(input event_item_t it);
		logic [4:0]  ev;
		logic [4:0]  ub_offset;
		logic [2:0]  st;
		logic [2:0]  sch;
		mode_t       m;
		outcome_t    oc;
		cmd_result_t r;
		ev = it.event_code;
		st = it.current_status;
		sch = it.schedule_status;
		m = op_mode;
		oc = OUT_HANDLED;
		event_cmds.delete();
		flush_first = 1'b0;

		// Busy cancels everything but a fault and a plain remote request
		if (ev != EV_FAIL && ev != EV_REMOTE && (!it.queue_empty || it.rotation_busy)) begin
			oc = OUT_BUSY;
		end else begin
			// Plain remote resolves to the schedule's normal or shift variant
			if (ev == EV_REMOTE) begin
				ev = (sch == ST_NORM || sch == ST_CLR_N || sch == ST_CLR_S) ?
					EV_REMOTE_NORM : EV_REMOTE_SHIFT;
			end
			case (ev)
				EV_REMOTE_NORM: begin
					if (m == OPM_MANUAL) begin
						if (st == ST_NORM) begin
							op_mode = OPM_REMOTE;
						end else if (st == ST_CLR) begin
							op_mode = OPM_REMOTE;
							push_cmd(CMD_WAIT);
							push_cmd(CMD_NORM);
						end else if (st == ST_SHIFT) begin
							op_mode = OPM_REMOTE;
							push3(CMD_CLR, CMD_WAIT, CMD_NORM);
						end else if (st == ST_FAIL) begin
							push_cmd(CMD_NORM);
						end
					end else if (m == OPM_REMOTE && st == ST_FAIL) begin
						push3(CMD_CLR, CMD_WAIT, CMD_NORM);
					end
				end
				EV_REMOTE_SHIFT: begin
					if (m == OPM_MANUAL) begin
						if (st == ST_NORM) begin
							op_mode = OPM_REMOTE;
							push3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						end else if (st == ST_CLR) begin
							push_cmd(CMD_WAIT);
							push_cmd(CMD_SHIFT);
							op_mode = OPM_REMOTE;
						end else if (st == ST_SHIFT) begin
							op_mode = OPM_REMOTE;
						end
					end else if (m == OPM_REMOTE && st == ST_FAIL) begin
						push3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
					end
				end
				EV_SCHED_N2S: begin
					if (m == OPM_REMOTE) begin
						if (it.error_present) begin
							push_cmd(CMD_FAIL);
						end else if (st == ST_NORM) begin
							push3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						end
					end
				end
				EV_SCHED_S2N: begin
					if (m == OPM_REMOTE) begin
						if (st == ST_SHIFT) begin
							push3(CMD_CLR, CMD_WAIT, CMD_NORM);
						end else if (st == ST_FAIL) begin
							push_cmd(CMD_NORM);
						end
					end
				end
				EV_MAN_NORM: begin
					if (m == OPM_REMOTE) begin
						if (st == ST_NORM) begin
							op_mode = OPM_MANUAL;
						end else if (st == ST_SHIFT) begin
							push3(CMD_CLR, CMD_WAIT, CMD_NORM);
							op_mode = OPM_MANUAL;
						end
					end else if (m == OPM_MANUAL) begin
						if (st == ST_CLR || st == ST_FAIL) begin
							push_cmd(CMD_NORM);
						end else if (st == ST_SHIFT) begin
							push3(CMD_CLR, CMD_WAIT, CMD_NORM);
						end
					end
				end
				EV_MAN_CLR: begin
					if (m == OPM_REMOTE) begin
						if (st == ST_NORM || st == ST_SHIFT) begin
							push_cmd(CMD_CLR);
							op_mode = OPM_MANUAL;
						end
					end else if (m == OPM_MANUAL) begin
						if (st == ST_NORM || st == ST_SHIFT || st == ST_FAIL) begin
							push_cmd(CMD_CLR);
						end
					end
				end
				EV_MAN_SHIFT: begin
					if (m == OPM_REMOTE) begin
						if (st == ST_NORM) begin
							push3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
							op_mode = OPM_MANUAL;
						end else if (st == ST_SHIFT) begin
							op_mode = OPM_MANUAL;
						end
					end else if (m == OPM_MANUAL) begin
						if (st == ST_NORM) begin
							push3(CMD_CLR, CMD_WAIT, CMD_SHIFT);
						end else if (st == ST_CLR || st == ST_FAIL) begin
							push_cmd(CMD_SHIFT);
						end
					end
				end
				EV_SW_NORM: begin
					oc = OUT_REFUSED;
					if (m == OPM_REMOTE) begin
						if (st == ST_NORM) begin
							op_mode = OPM_MANUAL;
							oc = OUT_HANDLED;
						end else if (st == ST_FAIL || st == ST_CLR) begin
							push_cmd(CMD_NORM);
							op_mode = OPM_MANUAL;
							oc = OUT_HANDLED;
						end
					end else if (m == OPM_MANUAL) begin
						if (st == ST_NORM || st == ST_CLR || st == ST_FAIL) begin
							push_cmd(CMD_NORM);
							oc = OUT_HANDLED;
						end
					end
				end
				EV_SW_CLR: begin
					oc = OUT_REFUSED;
					if (m == OPM_REMOTE) begin
						if (st == ST_NORM || st == ST_FAIL || st == ST_SHIFT) begin
							push_cmd(CMD_CLR);
							op_mode = OPM_MANUAL;
							oc = OUT_HANDLED;
						end
					end else if (m == OPM_MANUAL) begin
						if (st <= ST_FAIL) begin
							push_cmd(CMD_CLR);
							oc = OUT_HANDLED;
						end
					end
				end
				EV_SW_SHIFT: begin
					oc = OUT_REFUSED;
					if (m == OPM_REMOTE) begin
						if (st == ST_CLR || st == ST_FAIL) begin
							push_cmd(CMD_SHIFT);
							op_mode = OPM_MANUAL;
							oc = OUT_HANDLED;
						end else if (st == ST_SHIFT) begin
							op_mode = OPM_MANUAL;
							oc = OUT_HANDLED;
						end
					end else if (m == OPM_MANUAL) begin
						if (st == ST_CLR || st == ST_SHIFT || st == ST_FAIL) begin
							push_cmd(CMD_SHIFT);
							oc = OUT_HANDLED;
						end
					end
				end
				EV_MAN_FAIL: begin
					oc = OUT_REFUSED;
					if (st <= ST_SHIFT && (m == OPM_REMOTE || m == OPM_MANUAL)) begin
						op_mode = OPM_MANUAL;
						push_cmd(CMD_FAIL);
						oc = OUT_HANDLED;
					end
				end
				EV_MONITOR: begin
					if (st == ST_CLR || st == ST_FAIL) begin
						push_cmd(CMD_NORM);
					end else if (st == ST_SHIFT) begin
						push3(CMD_CLR, CMD_WAIT, CMD_NORM);
					end
					op_mode = OPM_MONITOR;
				end
				EV_MON_RELEASE: begin
					if (st == ST_NORM) begin
						push_cmd(CMD_NORM);
					end else if (st == ST_CLR || st == ST_FAIL) begin
						push_cmd(CMD_WAIT);
					end else if (st == ST_SHIFT) begin
						push_cmd(CMD_CLR);
						push_cmd(CMD_WAIT);
					end
					op_mode = OPM_REMOTE;
				end
				EV_FAIL: begin
					// Fault only acts under remote outside normal schedule time
					if (m == OPM_REMOTE && (sch == ST_CLR_N || sch == ST_CLR ||
							sch == ST_SHIFT || sch == ST_CLR_S)) begin
						if (st != ST_FAIL) begin
							push_cmd(CMD_FAIL);
						end
					end else begin
						oc = OUT_REFUSED;
					end
				end
				EV_POWER_OFF: begin
					if ((m == OPM_REMOTE || m == OPM_MANUAL) && st == ST_SHIFT) begin
						flush_first = 1'b1;
						push_cmd(CMD_POFF);
						outage_flag = 1'b1;
					end else begin
						oc = OUT_REFUSED;
					end
				end
				EV_POWER_ON: begin
					// Restore is skipped when the fault pattern already shows the target
					if (sch == ST_NORM || sch == ST_CLR_S) begin
						if (fault_pat != ST_NORM) begin
							push_cmd(CMD_NORM);
						end
					end else if (sch == ST_CLR) begin
						if (fault_pat != ST_CLR) begin
							push_cmd(CMD_CLR);
						end
					end else if (sch == ST_SHIFT || sch == ST_CLR_N) begin
						if (fault_pat != ST_SHIFT) begin
							push_cmd(CMD_WAIT);
							push_cmd(CMD_SHIFT);
						end
					end
					outage_flag = 1'b0;
				end
				EV_FAULT_CLR: begin
					if (st == ST_FAIL) begin
						if (m == OPM_REMOTE) begin
							push_status(sch);
						end else if (m == OPM_MANUAL) begin
							push_status(it.status_before_fail);
						end else if (m == OPM_MONITOR) begin
							push_cmd(CMD_NORM);
						end
					end
				end
				EV_FAIL_BACK: begin
					op_mode = OPM_REMOTE;
					if (st == ST_FAIL) begin
						push_cmd(CMD_NORM);
					end
				end
				EV_UB_NORM, EV_UB_CLR, EV_UB_SHIFT, EV_UB_FAIL: begin
					if (m == OPM_REMOTE) begin
						ub_offset = ev - EV_UB_NORM;
						push_cmd(ub_offset[2:0]);
					end else begin
						oc = OUT_REFUSED;
					end
				end
				default: begin
					oc = OUT_REFUSED;   // codes past the last defined event
				end
			endcase
		end

		// No command still yields one closing transaction
		if (event_cmds.size() == 0) begin
			r = '{command: CMD_NORM, has_command: 1'b0, flush_queue: 1'b0,
				outcome: oc, last: 1'b1};
			due_results.push_back(r);
		end else begin
			for (int k = 0; k < event_cmds.size(); k++) begin
				r.command = event_cmds[k];
				r.has_command = 1'b1;
				r.flush_queue = flush_first && (k == 0);
				r.outcome = oc;
				r.last = (k == event_cmds.size() - 1);
				due_results.push_back(r);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none, often a few cycles, now and then a long stall
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Bias toward the four real states; clear variants less, unused codes rarely
	function automatic logic [2:0] pick_status();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78) begin
			return 3'($urandom_range(0, 3));
		end else if (r < 94) begin
			return 3'($urandom_range(4, 5));
		end
		return 3'($urandom_range(6, 7));
	endfunction

	function automatic event_item_t make_event(input logic [4:0] ev, input logic [2:0] st,
			input logic [2:0] sch, input logic [2:0] bf, input logic qe,
			input logic rb, input logic err);
		event_item_t it;
		it = '{event_code: ev, current_status: st, schedule_status: sch,
			status_before_fail: bf, queue_empty: qe, rotation_busy: rb,
			error_present: err};
		return it;
	endfunction

	// Mostly well-formed events with idle queue; some busy, some raw noise
	function automatic event_item_t random_event();
		event_item_t it;
		if ($urandom_range(0, 99) < 85) begin
			it.event_code = 5'($urandom_range(0, 22));
			it.current_status = pick_status();
			it.schedule_status = pick_status();
			it.status_before_fail = pick_status();
			it.queue_empty = ($urandom_range(0, 9) != 0);
			it.rotation_busy = ($urandom_range(0, 9) == 0);
		end else begin
			it.event_code = 5'($urandom);
			it.current_status = 3'($urandom);
			it.schedule_status = 3'($urandom);
			it.status_before_fail = 3'($urandom);
			it.queue_empty = 1'($urandom);
			it.rotation_busy = 1'($urandom);
		end
		it.error_present = 1'($urandom);
		return it;
	endfunction

	// Drives one event transaction at the falling edge and returns just after the
	// rising edge that accepted it. Valid stays high so a back-to-back event
	// simply replaces the payload.
	task automatic send_event(input event_item_t it);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid           <= 1'b1;
		event_code         <= it.event_code;
		current_status     <= it.current_status;
		schedule_status    <= it.schedule_status;
		status_before_fail <= it.status_before_fail;
		queue_empty        <= it.queue_empty;
		rotation_busy      <= it.rotation_busy;
		error_present      <= it.error_present;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_event_cmds(it);
	endtask

	// Stops sending and waits until every owed transaction has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register write only while the block is idle
	task automatic write_fault_pat(input logic [2:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		fault_pat = value;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Walk through every event family but fail-back, busy cancel, the busy-exempt events,
	// unknown codes and unused status codes. Mode carries from one to the next.
	task automatic test_directed_events();
		// remote: fail display restored via rotation, normal and shift time
		send_event(make_event(EV_REMOTE, ST_FAIL, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_REMOTE, ST_FAIL, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b0));
		// schedule change with an error present goes to fail
		send_event(make_event(EV_SCHED_N2S, ST_NORM, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b1));
		send_event(make_event(EV_SCHED_N2S, ST_NORM, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_SCHED_S2N, ST_SHIFT, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		// last event code, unit-B fail under remote
		send_event(make_event(EV_UB_FAIL, ST_NORM, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		// busy: cancelled, except for fault and plain remote
		send_event(make_event(EV_MAN_SHIFT, ST_NORM, ST_NORM, ST_NORM, 1'b0, 1'b0, 1'b0));
		send_event(make_event(EV_FAIL, ST_NORM, ST_CLR_S, ST_NORM, 1'b1, 1'b1, 1'b0));
		send_event(make_event(EV_REMOTE, ST_FAIL, ST_CLR_S, ST_NORM, 1'b0, 1'b1, 1'b0));
		// power-off flushes the queue first, recovery restores shift
		send_event(make_event(EV_POWER_OFF, ST_SHIFT, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_POWER_ON, ST_FAIL, ST_CLR_N, ST_NORM, 1'b1, 1'b0, 1'b0));
		// into manual, then fault recovery from the saved status
		send_event(make_event(EV_MAN_CLR, ST_NORM, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_FAULT_CLR, ST_FAIL, ST_NORM, ST_CLR_S, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_FAULT_CLR, ST_FAIL, ST_NORM, 3'd7, 1'b1, 1'b0, 1'b0));
		// manual fail accepted, then refused from fail
		send_event(make_event(EV_MAN_FAIL, ST_CLR, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_MAN_FAIL, ST_FAIL, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		// refusals in manual
		send_event(make_event(EV_SW_SHIFT, ST_CLR_N, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_UB_NORM, ST_NORM, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		// monitor entry, fault recovery and fault refusal there, release
		send_event(make_event(EV_MONITOR, ST_SHIFT, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_FAULT_CLR, ST_FAIL, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_FAIL, ST_NORM, ST_SHIFT, ST_NORM, 1'b1, 1'b0, 1'b0));
		send_event(make_event(EV_MON_RELEASE, ST_SHIFT, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b0));
		// unused schedule code under remote gives no command
		send_event(make_event(EV_FAULT_CLR, ST_FAIL, 3'd6, ST_NORM, 1'b1, 1'b0, 1'b0));
		// undefined event codes, lowest and highest
		send_event(make_event(5'd23, ST_NORM, ST_NORM, ST_NORM, 1'b1, 1'b0, 1'b1));
		send_event(make_event(5'd31, 3'd7, 3'd7, 3'd7, 1'b1, 1'b0, 1'b1));
	endtask

	// Power recovery against every schedule status for several fault patterns,
	// both extremes included
	task automatic test_fault_pat_sweep();
		logic [2:0] patterns[4];
		patterns = '{3'd5, ST_CLR, ST_SHIFT, ST_NORM};
		foreach (patterns[p]) begin
			write_fault_pat(patterns[p]);
			for (int s = ST_NORM; s <= ST_CLR_S; s++) begin
				send_event(make_event(EV_POWER_ON, ST_FAIL, 3'(s), ST_NORM,
					1'b1, 1'b0, 1'b0));
			end
		end
	endtask

	// Random traffic in phases with a fresh fault pattern each; one phase starts
	// with no idling at all and another drains halfway through
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			write_fault_pat(3'($urandom_range(0, 5)));
			for (int n = 0; n < 100; n++) begin
				no_gaps = (phase == 1 && n < 40);
				if (phase == 2 && n == 50) begin
					wait_idle();
				end
				send_event(random_event());
			end
			no_gaps = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure and result checking
	// ------------------------------------------------------------------

	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (no_gaps) begin
				out_ready <= 1'b1;
				stall = 0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	function automatic void check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, name, expv, actv);
		end
	endfunction

	// Every accepted output transaction is matched against the oldest expectation
	always @(posedge clk) begin : result_check
		cmd_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected transaction, expected none, actual cmd %0d last %0d",
					$time, command, last);
			end else begin
				want = due_results.pop_front();
				check_field("command", want.command, command);
				check_field("has_command", want.has_command, has_command);
				check_field("flush_queue", want.flush_queue, flush_queue);
				check_field("outcome", want.outcome, outcome);
				check_field("last", want.last, last);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		error_count = 0;
		cycle_count = 0;
		no_gaps = 1'b0;
		in_valid = 1'b0;
		event_code = '0;
		current_status = '0;
		schedule_status = '0;
		status_before_fail = '0;
		queue_empty = 1'b1;
		rotation_busy = 1'b0;
		error_present = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		op_mode = OPM_REMOTE;
		outage_flag = 1'b0;
		fault_pat = ST_NORM;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_events();
		test_fault_pat_sweep();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### lane_sign_mode_event_sequencer.f
rtl/lsme_pkg.sv
rtl/lsme_front.sv
rtl/lsme_queue.sv
rtl/lsme_back.sv
rtl/lane_sign_mode_event_sequencer.sv
tb/tb_lane_sign_mode_event_sequencer.sv
